@@ hdl/etmb_pkg.sv @@
// ----------------------------------------------------------------------------
// etmb_pkg
// Shared types, constants and tables of the Euler TRS matrix builder.
// ----------------------------------------------------------------------------
package etmb_pkg;

   // Element format.
   localparam int ELEM_BITS = 32;
   localparam int FRAC_BITS = 16;

   // Internal widths: rotation terms in Q2.30 with headroom, products, sums.
   localparam int Q_W    = 34;
   localparam int PROD_W = 2 * Q_W;
   localparam int ACC_W  = 52;
   localparam int MOD_W  = 34;
   localparam int ANG_W  = 27;

   // Channel widths.
   localparam int REQ_DATA_W = 328;
   localparam int RSP_DATA_W = 4 * ELEM_BITS;
   localparam int CSR_W      = 2;

   // Request field offsets inside tdata.
   localparam int F_BASE_INDEX = 0;
   localparam int F_BASE_VALUE = 4;
   localparam int F_PITCH      = 36;
   localparam int F_YAW        = 68;
   localparam int F_ROLL       = 100;
   localparam int F_TRANS_X    = 132;
   localparam int F_SCALE_X    = 228;

   // Request kinds and register indexes.
   localparam logic REQ_LOAD    = 1'b0;
   localparam logic REQ_COMPUTE = 1'b1;
   localparam logic CSR_ROTATION_ORDER = 1'b0;
   localparam logic CSR_USE_BASE       = 1'b1;

   // Rotation orders.
   localparam logic [1:0] ORDER_XYZ = 2'd0;
   localparam logic [1:0] ORDER_YXZ = 2'd1;
   localparam logic [1:0] ORDER_ZXY = 2'd2;

   // Fixed-point constants.
   localparam logic signed [Q_W-1:0] Q30_ONE         = Q_W'(1) <<< 30;
   localparam logic signed [Q_W-1:0] CORDIC_GAIN     = Q_W'(32'h26DD3B6A);
   localparam logic signed [Q_W-1:0] RAD_PER_DEG_Q30 = Q_W'(18740330);
   localparam logic [MOD_W-1:0] FULL_TURN = MOD_W'(360) << FRAC_BITS;
   localparam logic [MOD_W-1:0] MOD_BIAS  = FULL_TURN * MOD_W'(92);
   localparam int CORDIC_STEPS = 30;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE, ST_ANG_INIT, ST_ANG_MOD, ST_ANG_FOLD, ST_ZMUL, ST_ZWB,
      ST_CORDIC, ST_ANG_STORE, ST_ROT, ST_SCALE, ST_MAT, ST_DRAIN, ST_OUT
   } ctrl_state_type;

   // Datapath operations.
   typedef enum logic [3:0] {
      DP_NOP, DP_CAPTURE, DP_ANG_INIT, DP_ANG_MOD, DP_ANG_FOLD, DP_ZMUL,
      DP_CORDIC, DP_ANG_STORE, DP_ROT, DP_SCALE, DP_MAT, DP_OUT
   } dp_op_type;

   // Operands and destinations of the rotation sequence.
   typedef enum logic [3:0] {
      OPD_SA, OPD_CA, OPD_SB, OPD_CB, OPD_SG, OPD_CG,
      OPD_PAB, OPD_PACB, OPD_QASB, OPD_ONE
   } opd_type;

   typedef enum logic [3:0] {
      DST_R00, DST_R01, DST_R02, DST_R10, DST_R11, DST_R12,
      DST_R20, DST_R21, DST_R22, DST_PAB, DST_PACB, DST_QASB
   } dst_type;

   typedef enum logic [1:0] {ACC_LOAD, ACC_ADD, ACC_SUB, ACC_NEG} acc_type;

   typedef struct packed {
      opd_type a;
      opd_type b;
      acc_type acc;
      dst_type dst;
   } rot_uop_type;

   // Command from the controller to the datapath.
   typedef struct packed {
      dp_op_type  op;
      logic [5:0] step;
      logic [1:0] angle;
      logic [1:0] order;
      logic       use_base;
   } dp_cmd_type;

   function automatic rot_uop_type mk_uop(input opd_type a, input opd_type b,
                                          input acc_type acc, input dst_type dst);
      rot_uop_type u;
      u.a = a;
      u.b = b;
      u.acc = acc;
      u.dst = dst;
      return u;
   endfunction

   // Sixteen multiply steps build the rotation; the first three form shared
   // products, the others accumulate the nine terms for the chosen order.
   function automatic rot_uop_type rot_ucode(input logic [1:0] order,
                                             input logic [3:0] step);
      rot_uop_type u;
      u = mk_uop(OPD_CA, OPD_CB, ACC_LOAD, DST_R22);
      case (step)
         4'd0: u = mk_uop(OPD_SA, OPD_SB, ACC_LOAD, DST_PAB);
         4'd1: u = mk_uop(OPD_SA, OPD_CB, ACC_LOAD, DST_PACB);
         4'd2: u = mk_uop(OPD_CA, OPD_SB, ACC_LOAD, DST_QASB);
         4'd3: u = mk_uop(OPD_CB, OPD_CG, ACC_LOAD, DST_R00);
         4'd15: u = mk_uop(OPD_CA, OPD_CB, ACC_LOAD, DST_R22);
         default: begin
            case (order)
               ORDER_YXZ: begin
                  case (step)
                     4'd4: u = mk_uop(OPD_PAB, OPD_SG, ACC_SUB, DST_R00);
                     4'd5: u = mk_uop(OPD_CB, OPD_SG, ACC_LOAD, DST_R01);
                     4'd6: u = mk_uop(OPD_PAB, OPD_CG, ACC_ADD, DST_R01);
                     4'd7: u = mk_uop(OPD_QASB, OPD_ONE, ACC_NEG, DST_R02);
                     4'd8: u = mk_uop(OPD_CA, OPD_SG, ACC_NEG, DST_R10);
                     4'd9: u = mk_uop(OPD_CA, OPD_CG, ACC_LOAD, DST_R11);
                     4'd10: u = mk_uop(OPD_SA, OPD_ONE, ACC_LOAD, DST_R12);
                     4'd11: u = mk_uop(OPD_SB, OPD_CG, ACC_LOAD, DST_R20);
                     4'd12: u = mk_uop(OPD_PACB, OPD_SG, ACC_ADD, DST_R20);
                     4'd13: u = mk_uop(OPD_SB, OPD_SG, ACC_LOAD, DST_R21);
                     default: u = mk_uop(OPD_PACB, OPD_CG, ACC_SUB, DST_R21);
                  endcase
               end
               ORDER_ZXY: begin
                  case (step)
                     4'd4: u = mk_uop(OPD_PAB, OPD_SG, ACC_ADD, DST_R00);
                     4'd5: u = mk_uop(OPD_CA, OPD_SG, ACC_LOAD, DST_R01);
                     4'd6: u = mk_uop(OPD_PACB, OPD_SG, ACC_LOAD, DST_R02);
                     4'd7: u = mk_uop(OPD_SB, OPD_CG, ACC_SUB, DST_R02);
                     4'd8: u = mk_uop(OPD_PAB, OPD_CG, ACC_LOAD, DST_R10);
                     4'd9: u = mk_uop(OPD_CB, OPD_SG, ACC_SUB, DST_R10);
                     4'd10: u = mk_uop(OPD_CA, OPD_CG, ACC_LOAD, DST_R11);
                     4'd11: u = mk_uop(OPD_PACB, OPD_CG, ACC_LOAD, DST_R12);
                     4'd12: u = mk_uop(OPD_SB, OPD_SG, ACC_ADD, DST_R12);
                     4'd13: u = mk_uop(OPD_QASB, OPD_ONE, ACC_LOAD, DST_R20);
                     default: u = mk_uop(OPD_SA, OPD_ONE, ACC_NEG, DST_R21);
                  endcase
               end
               default: begin
                  case (step)
                     4'd4: u = mk_uop(OPD_CB, OPD_SG, ACC_LOAD, DST_R01);
                     4'd5: u = mk_uop(OPD_SB, OPD_ONE, ACC_NEG, DST_R02);
                     4'd6: u = mk_uop(OPD_PAB, OPD_CG, ACC_LOAD, DST_R10);
                     4'd7: u = mk_uop(OPD_CA, OPD_SG, ACC_SUB, DST_R10);
                     4'd8: u = mk_uop(OPD_PAB, OPD_SG, ACC_LOAD, DST_R11);
                     4'd9: u = mk_uop(OPD_CA, OPD_CG, ACC_ADD, DST_R11);
                     4'd10: u = mk_uop(OPD_PACB, OPD_ONE, ACC_LOAD, DST_R12);
                     4'd11: u = mk_uop(OPD_QASB, OPD_CG, ACC_LOAD, DST_R20);
                     4'd12: u = mk_uop(OPD_SA, OPD_SG, ACC_ADD, DST_R20);
                     4'd13: u = mk_uop(OPD_QASB, OPD_SG, ACC_LOAD, DST_R21);
                     default: u = mk_uop(OPD_SA, OPD_CG, ACC_SUB, DST_R21);
                  endcase
               end
            endcase
         end
      endcase
      return u;
   endfunction

   // Arctangent table for the CORDIC, Q2.30.
   function automatic logic signed [Q_W-1:0] atan_q30(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         5'd24: v = 32'h0000003F;
         5'd25: v = 32'h0000001F;
         5'd26: v = 32'h0000000F;
         5'd27: v = 32'h00000008;
         5'd28: v = 32'h00000004;
         5'd29: v = 32'h00000002;
         default: v = 32'h00000000;
      endcase
      return Q_W'(v);
   endfunction

endpackage

@@ hdl/etmb_ctrl.sv @@
// ----------------------------------------------------------------------------
// etmb_ctrl
// Sequencer of the matrix builder: holds the configuration registers, runs
// the angle, rotation, scaling and matrix phases and drives both handshakes.
// ----------------------------------------------------------------------------
module etmb_ctrl import etmb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_kind,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [1:0]       rsp_column,
   output logic             rsp_last,
   input  logic             csr_wen,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   output dp_cmd_type       cmd
);

   ctrl_state_type state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [1:0] ang_ff, ang_in;
   logic [1:0] order_ff;
   logic       use_base_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff    <= ORDER_XYZ;
         use_base_ff <= 1'b0;
      end else if (csr_wen) begin
         if (csr_index == CSR_ROTATION_ORDER) order_ff <= csr_wdata[1:0];
         else use_base_ff <= csr_wdata[0];
      end
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         ang_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ang_ff   <= ang_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ang_in       = ang_ff;
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;
      rsp_column   = cnt_ff[1:0];
      rsp_last     = 1'b0;
      cmd.op       = DP_NOP;
      cmd.step     = cnt_ff;
      cmd.angle    = ang_ff;
      cmd.order    = (order_ff == 2'd3) ? ORDER_XYZ : order_ff;
      cmd.use_base = use_base_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op = DP_CAPTURE;
               ang_in = '0;
               if (req_kind == REQ_COMPUTE) state_in = ST_ANG_INIT;
            end
         end
         ST_ANG_INIT: begin
            cmd.op   = DP_ANG_INIT;
            cnt_in   = '0;
            state_in = ST_ANG_MOD;
         end
         ST_ANG_MOD: begin
            cmd.op = DP_ANG_MOD;
            if (cnt_ff == 6'd7) begin
               cnt_in   = '0;
               state_in = ST_ANG_FOLD;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_ANG_FOLD: begin
            cmd.op   = DP_ANG_FOLD;
            state_in = ST_ZMUL;
         end
         ST_ZMUL: begin
            cmd.op   = DP_ZMUL;
            state_in = ST_ZWB;
         end
         ST_ZWB: begin
            cnt_in   = '0;
            state_in = ST_CORDIC;
         end
         ST_CORDIC: begin
            cmd.op = DP_CORDIC;
            if (cnt_ff == 6'(CORDIC_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_ANG_STORE;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_ANG_STORE: begin
            cmd.op = DP_ANG_STORE;
            cnt_in = '0;
            if (ang_ff == 2'd2) begin
               state_in = ST_ROT;
            end else begin
               ang_in   = ang_ff + 2'd1;
               state_in = ST_ANG_INIT;
            end
         end
         ST_ROT: begin
            cmd.op = DP_ROT;
            if (cnt_ff == 6'd15) begin
               cnt_in   = '0;
               state_in = ST_SCALE;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_SCALE: begin
            // Column in bits 3:2, row in bits 1:0; rows run 0 to 2.
            cmd.op = DP_SCALE;
            if (cnt_ff[3:0] == 4'b1010) begin
               cnt_in   = '0;
               state_in = use_base_ff ? ST_MAT : ST_DRAIN;
            end else if (cnt_ff[1:0] == 2'd2) begin
               cnt_in = cnt_ff + 6'd2;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_MAT: begin
            cmd.op = DP_MAT;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            cnt_in   = '0;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            cmd.op     = DP_OUT;
            rsp_tvalid = 1'b1;
            rsp_last   = (cnt_ff[1:0] == 2'd3);
            if (rsp_tready) begin
               if (cnt_ff[1:0] == 2'd3) begin
                  cnt_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 6'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ hdl/etmb_datapath.sv @@
// ----------------------------------------------------------------------------
// etmb_datapath
// Angle reduction, iterative CORDIC, one shared multiplier with a registered
// product and a write-back stage, and the base, local and result matrices.
// ----------------------------------------------------------------------------
module etmb_datapath import etmb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   input  logic                  req_kind,
   input  logic [REQ_DATA_W-1:0] req_data,
   output logic [RSP_DATA_W-1:0] rsp_data
);

   localparam logic signed [ACC_W-1:0] EMAX = (ACC_W'(1) <<< (ELEM_BITS - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] EMIN = -EMAX - ACC_W'(1);
   localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(FULL_TURN >> 1);
   localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(FULL_TURN >> 2);

   function automatic logic signed [PROD_W-1:0] rnd_q30(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      t = p + (PROD_W'(1) <<< 29);
      return t >>> 30;
   endfunction

   function automatic logic signed [PROD_W-1:0] rnd_q16(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      t = p + (PROD_W'(1) <<< (FRAC_BITS - 1));
      return t >>> FRAC_BITS;
   endfunction

   function automatic logic signed [ELEM_BITS-1:0] sat_elem(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] t;
      t = (v > EMAX) ? EMAX : ((v < EMIN) ? EMIN : v);
      return t[ELEM_BITS-1:0];
   endfunction

   function automatic logic signed [Q_W-1:0] ext_elem(input logic signed [ELEM_BITS-1:0] v);
      return {{(Q_W - ELEM_BITS){v[ELEM_BITS-1]}}, v};
   endfunction

   // Captured request fields.
   logic signed [ELEM_BITS-1:0] angle_ff [0:2];
   logic signed [ELEM_BITS-1:0] scale_ff [0:2];

   // Angle unit.
   logic [MOD_W-1:0]        modx_ff;
   logic signed [ANG_W-1:0] ang_r_ff;
   logic                    neg_ff;
   logic signed [Q_W-1:0]   x_ff, y_ff, z_ff;
   logic signed [Q_W-1:0]   trig_ff [0:5];
   logic signed [Q_W-1:0]   tmp_ff [0:2];
   logic signed [Q_W-1:0]   rot_ff [0:8];

   // Matrices.
   logic signed [ELEM_BITS-1:0] base_ff [0:15];
   logic signed [ELEM_BITS-1:0] loc_ff [0:15];
   logic signed [ELEM_BITS-1:0] res_ff [0:15];
   logic signed [ACC_W-1:0]     acc_ff;

   // Multiplier pipeline.
   logic signed [Q_W-1:0]    mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff;
   dp_cmd_type               wb_ff;

   rot_uop_type uop_iss, uop_wb;

   function automatic logic signed [Q_W-1:0] opd_value(
      input opd_type o, input logic signed [Q_W-1:0] t0, input logic signed [Q_W-1:0] t1,
      input logic signed [Q_W-1:0] t2, input logic signed [Q_W-1:0] t3,
      input logic signed [Q_W-1:0] t4, input logic signed [Q_W-1:0] t5,
      input logic signed [Q_W-1:0] p0, input logic signed [Q_W-1:0] p1,
      input logic signed [Q_W-1:0] p2);
      logic signed [Q_W-1:0] v;
      case (o)
         OPD_SA:   v = t0;
         OPD_CA:   v = t1;
         OPD_SB:   v = t2;
         OPD_CB:   v = t3;
         OPD_SG:   v = t4;
         OPD_CG:   v = t5;
         OPD_PAB:  v = p0;
         OPD_PACB: v = p1;
         OPD_QASB: v = p2;
         default:  v = Q30_ONE;
      endcase
      return v;
   endfunction

   // Operand selection for the shared multiplier.
   logic [3:0] scale_idx;
   always_comb begin
      uop_iss   = rot_ucode(cmd.order, cmd.step[3:0]);
      scale_idx = 4'({cmd.step[3:2], 1'b0}) + 4'(cmd.step[3:2]) + 4'(cmd.step[1:0]);
      mul_a     = '0;
      mul_b     = '0;
      case (cmd.op)
         DP_ZMUL: begin
            mul_a = {{(Q_W - ANG_W){ang_r_ff[ANG_W-1]}}, ang_r_ff};
            mul_b = RAD_PER_DEG_Q30;
         end
         DP_ROT: begin
            mul_a = opd_value(uop_iss.a, trig_ff[0], trig_ff[1], trig_ff[2], trig_ff[3],
                              trig_ff[4], trig_ff[5], tmp_ff[0], tmp_ff[1], tmp_ff[2]);
            mul_b = opd_value(uop_iss.b, trig_ff[0], trig_ff[1], trig_ff[2], trig_ff[3],
                              trig_ff[4], trig_ff[5], tmp_ff[0], tmp_ff[1], tmp_ff[2]);
         end
         DP_SCALE: begin
            mul_a = rot_ff[scale_idx];
            mul_b = ext_elem(scale_ff[cmd.step[3:2]]);
         end
         DP_MAT: begin
            mul_a = ext_elem(loc_ff[{cmd.step[1:0], cmd.step[3:2]}]);
            mul_b = ext_elem(base_ff[{cmd.step[5:4], cmd.step[1:0]}]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Product register.
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // Delayed command, and base store with identity reset, written by load transactions.
   always_ff @(posedge clock) begin
      if (reset) begin
         wb_ff.op <= DP_NOP;
         for (int i = 0; i < 16; i++) begin
            base_ff[i] <= (i % 5 == 0) ? (ELEM_BITS'(1) <<< FRAC_BITS) : '0;
         end
      end else begin
         wb_ff.op <= cmd.op;
         if (cmd.op == DP_CAPTURE && req_kind == REQ_LOAD) begin
            base_ff[req_data[F_BASE_INDEX +: 4]] <= req_data[F_BASE_VALUE +: ELEM_BITS];
         end
      end
      wb_ff.step     <= cmd.step;
      wb_ff.angle    <= cmd.angle;
      wb_ff.order    <= cmd.order;
      wb_ff.use_base <= cmd.use_base;
   end

   // Capture of compute fields and the fixed part of the local matrix, and write-back of the scaled terms.
   always_ff @(posedge clock) begin
      if (cmd.op == DP_CAPTURE && req_kind == REQ_COMPUTE) begin
         angle_ff[0] <= req_data[F_PITCH +: ELEM_BITS];
         angle_ff[1] <= req_data[F_YAW +: ELEM_BITS];
         angle_ff[2] <= req_data[F_ROLL +: ELEM_BITS];
         for (int i = 0; i < 3; i++) begin
            scale_ff[i]  <= req_data[F_SCALE_X + i * ELEM_BITS +: ELEM_BITS];
            loc_ff[12 + i] <= req_data[F_TRANS_X + i * ELEM_BITS +: ELEM_BITS];
            loc_ff[i * 4 + 3] <= '0;
         end
         loc_ff[15] <= ELEM_BITS'(1) <<< FRAC_BITS;
      end else if (wb_ff.op == DP_SCALE) begin
         loc_ff[wb_ff.step[3:0]] <= sat_elem(ACC_W'(rnd_q30(prod_ff)));
      end
   end

   // Angle reduction, fold into a half turn, and CORDIC iterations.
   logic signed [Q_W-1:0]   deg_ext, xs, ys;
   logic [MOD_W-1:0]        mod_sub;
   logic signed [ANG_W-1:0] fold_r;
   logic                    fold_neg;
   always_comb begin
      deg_ext  = ext_elem(angle_ff[cmd.angle == 2'd3 ? 2'd0 : cmd.angle]);
      mod_sub  = FULL_TURN << (3'd7 - cmd.step[2:0]);
      fold_r   = signed'(modx_ff[ANG_W-1:0]);
      fold_neg = 1'b0;
      if (fold_r > HALF_TURN) fold_r = fold_r - (HALF_TURN <<< 1);
      if (fold_r > QUARTER_TURN) begin
         fold_r   = fold_r - HALF_TURN;
         fold_neg = 1'b1;
      end else if (fold_r < -QUARTER_TURN) begin
         fold_r   = fold_r + HALF_TURN;
         fold_neg = 1'b1;
      end
      xs = x_ff >>> cmd.step[4:0];
      ys = y_ff >>> cmd.step[4:0];
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         DP_ANG_INIT: modx_ff <= deg_ext[Q_W-1] ? MOD_W'(deg_ext) + MOD_BIAS : MOD_W'(deg_ext);
         DP_ANG_MOD: if (modx_ff >= mod_sub) modx_ff <= modx_ff - mod_sub;
         DP_ANG_FOLD: begin
            ang_r_ff <= fold_r;
            neg_ff   <= fold_neg;
         end
         default: ;
      endcase
      if (wb_ff.op == DP_ZMUL) begin
         z_ff <= Q_W'(rnd_q16(prod_ff));
         x_ff <= CORDIC_GAIN;
         y_ff <= '0;
      end else if (cmd.op == DP_CORDIC) begin
         if (!z_ff[Q_W-1]) begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - atan_q30(cmd.step[4:0]);
         end else begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + atan_q30(cmd.step[4:0]);
         end
      end
      if (cmd.op == DP_ANG_STORE) begin
         trig_ff[{cmd.angle, 1'b0}] <= neg_ff ? -y_ff : y_ff;
         trig_ff[{cmd.angle, 1'b1}] <= neg_ff ? -x_ff : x_ff;
      end
   end

   // Rotation term write-back: accumulate into the named destination.
   logic signed [Q_W-1:0] rot_term, rot_cur, rot_new;
   always_comb begin
      uop_wb   = rot_ucode(wb_ff.order, wb_ff.step[3:0]);
      rot_term = Q_W'(rnd_q30(prod_ff));
      case (uop_wb.dst)
         DST_PAB:  rot_cur = tmp_ff[0];
         DST_PACB: rot_cur = tmp_ff[1];
         DST_QASB: rot_cur = tmp_ff[2];
         default:  rot_cur = rot_ff[uop_wb.dst];
      endcase
      case (uop_wb.acc)
         ACC_ADD: rot_new = rot_cur + rot_term;
         ACC_SUB: rot_new = rot_cur - rot_term;
         ACC_NEG: rot_new = -rot_term;
         default: rot_new = rot_term;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wb_ff.op == DP_ROT) begin
         case (uop_wb.dst)
            DST_PAB:  tmp_ff[0] <= rot_new;
            DST_PACB: tmp_ff[1] <= rot_new;
            DST_QASB: tmp_ff[2] <= rot_new;
            default:  rot_ff[uop_wb.dst] <= rot_new;
         endcase
      end
   end

   // Matrix product against the base: four terms per result element.
   logic signed [ACC_W-1:0] mat_term, mat_sum;
   always_comb begin
      mat_term = ACC_W'(rnd_q16(prod_ff));
      mat_sum  = (wb_ff.step[1:0] == 2'd0) ? mat_term : acc_ff + mat_term;
   end

   always_ff @(posedge clock) begin
      if (wb_ff.op == DP_MAT) begin
         acc_ff <= mat_sum;
         if (wb_ff.step[1:0] == 2'd3) res_ff[{wb_ff.step[5:4], wb_ff.step[3:2]}] <= sat_elem(mat_sum);
      end
   end

   // Result column, rows from the lowest bits up.
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         rsp_data[r * ELEM_BITS +: ELEM_BITS] = cmd.use_base ?
            res_ff[{cmd.step[1:0], 2'(r)}] : loc_ff[{cmd.step[1:0], 2'(r)}];
      end
   end

endmodule

@@ hdl/euler_trs_matrix_builder.sv @@
// ----------------------------------------------------------------------------
// euler_trs_matrix_builder
// Column-major 4x4 transform from Euler angles, translation and scale.
// ----------------------------------------------------------------------------
// The request stream carries one transaction per item: tuser selects a base
// element load or a compute. A load writes one base element and returns
// nothing. A compute returns four column transactions on the response
// stream, column number in tuser and tlast on column three.
// A compute reduces each angle by repeated subtraction, folds it, scales it
// to radians and runs a thirty-step CORDIC, one angle after the other.
// The shared multiplier then forms the rotation, the scaling and, with
// use_base set, the base product, followed by a drain state.
// One item is in flight at a time: a new request is taken once the fourth
// column has gone. A stalled receiver holds the column steady until tready.
// Synchronous reset clears both registers and sets the base to identity.
// Configuration writes take effect at the clock edge and are to be made
// while idle by the user; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module euler_trs_matrix_builder import etmb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // base_index, base_value, angle_pitch, angle_yaw, angle_roll,
   // trans_x, trans_y, trans_z, scale_x, scale_y, scale_z, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type
   input  logic [0:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // elem_row0, elem_row1, elem_row2, elem_row3
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // column_number
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_wen,
   input  logic [0:0]            csr_index,
   input  logic [CSR_W-1:0]      csr_wdata
);

   dp_cmd_type cmd;

   // Sequencer.
   etmb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser[0]),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_column (rsp_tuser),
      .rsp_last   (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index[0]),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd)
   );

   // Arithmetic and storage.
   etmb_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_kind (req_tuser[0]),
      .req_data (req_tdata),
      .rsp_data (rsp_tdata)
   );

endmodule

@@ sim/tb_euler_trs_matrix_builder.sv @@
// ----------------------------------------------------------------------------
// tb_euler_trs_matrix_builder
// Self-checking bench for the Euler TRS matrix builder.
// ----------------------------------------------------------------------------
// Base loads and transform requests are sent on the request stream. Each
// accepted compute is predicted here in fixed point: angle reduction, CORDIC,
// rotation terms for the current order, scaling, translation and the
// optional base product. The four column transactions that come back are
// compared field by field. The run steps through every rotation order and
// both base settings, with phases of random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_euler_trs_matrix_builder;
   import etmb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] ORDER_SPARE = 2'd3;
   localparam longint ELEM_MAX = 64'sd2147483647;
   localparam longint ELEM_MIN = -64'sd2147483648;
   localparam longint FULL_DEG = 64'sd360 <<< FRAC_BITS;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      logic        kind;
      logic [3:0]  index;
      logic [31:0] value;
      logic [31:0] angle [3];
      logic [31:0] trans [3];
      logic [31:0] scale [3];
   } request_type;

   typedef struct {
      logic [1:0]  column;
      logic [31:0] row [4];
      logic        last;
   } column_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_wen = 1'b0;
   logic [0:0]            csr_index = '0;
   logic [CSR_W-1:0]      csr_wdata = '0;

   request_type pending_reqs [$];
   column_type  expected_cols [$];
   int       issued = 0, accepted = 0, mismatches = 0, columns_seen = 0;
   int       cycles = 0, loads_sent = 0, computes_sent = 0;
   int       send_idle_pct = 0, recv_stall_pct = 0;
   logic [1:0] cur_order = ORDER_XYZ;
   logic       cur_use_base = 1'b0;
   longint     base_mat [16];

   longint atan_tab [30] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
      64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};

   euler_trs_matrix_builder uut (.*);

   // Clock and cycle limit.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_euler_trs_matrix_builder: errors");
         $finish;
      end
   end

   // Fixed-point helpers: rounding shift with ties upwards, and saturation.
   function automatic longint rnd_shift(longint x, int n);
      return (x + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic longint sat32(longint v);
      return v > ELEM_MAX ? ELEM_MAX : (v < ELEM_MIN ? ELEM_MIN : v);
   endfunction

   function automatic longint q30_mul(longint a, longint b);
      return rnd_shift(a * b, 30);
   endfunction

   // Sine and cosine in Q2.30 of an angle in Q16.16 degrees.
   task automatic angle_sin_cos(input logic [31:0] deg, output longint s,
                                output longint c);
      longint r, x, y, z, xs, ys;
      bit     flip;
      r = longint'($signed(deg)) % FULL_DEG;
      x = 64'sh26DD3B6A;
      y = 0;
      flip = 1'b0;
      if (r < 0) r += FULL_DEG;
      if (r > FULL_DEG / 2) r -= FULL_DEG;
      if (r > FULL_DEG / 4) begin
         r -= FULL_DEG / 2;
         flip = 1'b1;
      end else if (r < -(FULL_DEG / 4)) begin
         r += FULL_DEG / 2;
         flip = 1'b1;
      end
      z = rnd_shift(r * 64'sd18740330, FRAC_BITS);
      for (int i = 0; i < 30; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= atan_tab[i];
         end else begin
            x += ys; y -= xs; z += atan_tab[i];
         end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endtask

   // Applies one accepted request: base loads update the local base copy,
   // computes queue the four expected columns.
   task automatic predict_columns(input logic [REQ_DATA_W-1:0] d, input logic kind);
      longint sa, ca, sb, cb, sg, cg, acc, sc;
      longint rot [3][3];
      longint loc [4][4];
      column_type col;
      if (kind == REQ_LOAD) begin
         base_mat[d[F_BASE_INDEX +: 4]] = longint'($signed(d[F_BASE_VALUE +: 32]));
         return;
      end
      angle_sin_cos(d[F_PITCH +: 32], sa, ca);
      angle_sin_cos(d[F_YAW +: 32], sb, cb);
      angle_sin_cos(d[F_ROLL +: 32], sg, cg);
      case (cur_order)
         ORDER_YXZ: begin
            rot[0][0] = q30_mul(cb, cg) - q30_mul(q30_mul(sa, sb), sg);
            rot[0][1] = q30_mul(cb, sg) + q30_mul(q30_mul(sa, sb), cg);
            rot[0][2] = -q30_mul(ca, sb);
            rot[1][0] = -q30_mul(ca, sg);
            rot[1][1] = q30_mul(ca, cg);
            rot[1][2] = sa;
            rot[2][0] = q30_mul(sb, cg) + q30_mul(q30_mul(sa, cb), sg);
            rot[2][1] = q30_mul(sb, sg) - q30_mul(q30_mul(sa, cb), cg);
         end
         ORDER_ZXY: begin
            rot[0][0] = q30_mul(cb, cg) + q30_mul(q30_mul(sa, sb), sg);
            rot[0][1] = q30_mul(ca, sg);
            rot[0][2] = q30_mul(q30_mul(sa, cb), sg) - q30_mul(sb, cg);
            rot[1][0] = q30_mul(q30_mul(sa, sb), cg) - q30_mul(cb, sg);
            rot[1][1] = q30_mul(ca, cg);
            rot[1][2] = q30_mul(q30_mul(sa, cb), cg) + q30_mul(sb, sg);
            rot[2][0] = q30_mul(ca, sb);
            rot[2][1] = -sa;
         end
         default: begin
            // The spare order code behaves as XYZ.
            rot[0][0] = q30_mul(cb, cg);
            rot[0][1] = q30_mul(cb, sg);
            rot[0][2] = -sb;
            rot[1][0] = q30_mul(q30_mul(sa, sb), cg) - q30_mul(ca, sg);
            rot[1][1] = q30_mul(q30_mul(sa, sb), sg) + q30_mul(ca, cg);
            rot[1][2] = q30_mul(sa, cb);
            rot[2][0] = q30_mul(q30_mul(ca, sb), cg) + q30_mul(sa, sg);
            rot[2][1] = q30_mul(q30_mul(ca, sb), sg) - q30_mul(sa, cg);
         end
      endcase
      rot[2][2] = q30_mul(ca, cb);
      for (int c = 0; c < 3; c++) begin
         sc = longint'($signed(d[F_SCALE_X + 32 * c +: 32]));
         for (int r = 0; r < 3; r++) loc[c][r] = sat32(rnd_shift(rot[c][r] * sc, 30));
         loc[c][3] = 0;
         loc[3][c] = longint'($signed(d[F_TRANS_X + 32 * c +: 32]));
      end
      loc[3][3] = 64'sd1 <<< FRAC_BITS;
      for (int c = 0; c < 4; c++) begin
         col.column = 2'(c);
         col.last = (c == 3);
         for (int r = 0; r < 4; r++) begin
            if (cur_use_base) begin
               acc = 0;
               for (int k = 0; k < 4; k++)
                  acc += rnd_shift(loc[k][r] * base_mat[c * 4 + k], FRAC_BITS);
               col.row[r] = 32'(sat32(acc));
            end else begin
               col.row[r] = 32'(loc[c][r]);
            end
         end
         expected_cols.push_back(col);
      end
   endtask

   // Request driver: holds the current transaction until it is taken, then
   // offers the next one unless a random gap is rolled.
   always @(negedge clock) begin
      request_type q;
      if (!reset && (!req_tvalid || accepted == issued)) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            q = pending_reqs.pop_front();
            req_tuser <= q.kind;
            req_tdata <= {4'h0, q.scale[2], q.scale[1], q.scale[0], q.trans[2],
                          q.trans[1], q.trans[0], q.angle[2], q.angle[1],
                          q.angle[0], q.value, q.index};
            req_tvalid <= 1'b1;
            issued <= issued + 1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // Request acceptance feeds the predictor.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         predict_columns(req_tdata, req_tuser[0]);
         accepted <= accepted + 1;
      end
   end

   // Response monitor: each column against the oldest expectation.
   always @(posedge clock) begin
      column_type want;
      bit      bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         columns_seen++;
         if (expected_cols.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected column %0d transaction at %0t", rsp_tuser, $realtime);
         end else begin
            want = expected_cols.pop_front();
            bad = (rsp_tuser != want.column) || (rsp_tlast != want.last);
            for (int r = 0; r < 4; r++)
               if (rsp_tdata[32 * r +: 32] != want.row[r]) bad = 1'b1;
            if (bad) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("column mismatch: expected col %0d last %b rows %h %h %h %h, got col %0d last %b rows %h %h %h %h",
                           want.column, want.last, want.row[0], want.row[1],
                           want.row[2], want.row[3], rsp_tuser, rsp_tlast,
                           rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                           rsp_tdata[127:96]);
            end
         end
      end
   end

   // Stimulus generation.
   function automatic logic [31:0] pick_angle();
      case ($urandom_range(5))
         0: return $urandom();
         1: return 32'($signed($urandom_range(1440)) - 720) <<< FRAC_BITS;
         2: return 32'(90 * ($signed($urandom_range(8)) - 4)) <<< FRAC_BITS;
         default: return 32'($signed($urandom_range(23592960)) - 32'sd11796480);
      endcase
   endfunction

   function automatic logic [31:0] pick_elem();
      case ($urandom_range(3))
         0: return $urandom();
         1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
         default: return 32'($signed($urandom_range(1048576)) - 32'sd524288);
      endcase
   endfunction

   function automatic request_type make_compute(logic [31:0] ang, logic [31:0] tr,
                                                logic [31:0] sc);
      request_type q;
      q.kind = REQ_COMPUTE;
      q.index = 4'($urandom());
      q.value = $urandom();
      for (int i = 0; i < 3; i++) begin
         q.angle[i] = ang;
         q.trans[i] = tr;
         q.scale[i] = sc;
      end
      return q;
   endfunction

   function automatic request_type make_load(logic [3:0] idx, logic [31:0] val);
      request_type q;
      q = make_compute($urandom(), $urandom(), $urandom());
      q.kind = REQ_LOAD;
      q.index = idx;
      q.value = val;
      return q;
   endfunction

   function automatic request_type make_random();
      request_type q;
      if ($urandom_range(99) < 30)
         return make_load(4'($urandom()), $urandom_range(1) ? pick_elem()
                          : 32'($signed($urandom_range(131072)) - 32'sd65536));
      q = make_compute(0, 0, 0);
      for (int i = 0; i < 3; i++) begin
         q.angle[i] = pick_angle();
         q.trans[i] = pick_elem();
         q.scale[i] = $urandom_range(2) ? 32'($signed($urandom_range(262144)) - 32'sd131072)
                      : pick_elem();
      end
      return q;
   endfunction

   task automatic write_reg(logic [0:0] idx, logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_ROTATION_ORDER) cur_order = val;
      else cur_use_base = val[0];
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic drain_all();
      while (pending_reqs.size() > 0 || accepted != issued || req_tvalid ||
             expected_cols.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   initial begin
      logic [1:0]       orders [7] = '{ORDER_XYZ, ORDER_YXZ, ORDER_ZXY, ORDER_SPARE,
                                       ORDER_XYZ, ORDER_YXZ, ORDER_ZXY};
      logic [CSR_W-1:0] bases [7] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd3, 2'd2, 2'd1};
      int               idle_mode [4][2] = '{'{0, 0}, '{64, 0}, '{0, 64}, '{21, 21}};
      for (int i = 0; i < 16; i++) base_mat[i] = (i % 5 == 0) ? (64'sd1 <<< FRAC_BITS) : 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes of every field, quarter turns, huge angles, loads.
      write_reg(CSR_ROTATION_ORDER, ORDER_XYZ);
      write_reg(CSR_USE_BASE, 2'd0);
      pending_reqs.push_back(make_compute(0, 0, 32'h00010000));
      pending_reqs.push_back(make_compute(32'h005A0000, 32'h7FFFFFFF, 32'h7FFFFFFF));
      pending_reqs.push_back(make_compute(32'hFFA60000, 32'h80000000, 32'h80000000));
      pending_reqs.push_back(make_compute(32'h00B40000, 32'hFFFFFFFF, 32'h00010000));
      pending_reqs.push_back(make_compute(32'h010E0000, 32'h00000001, 32'hFFFF0000));
      pending_reqs.push_back(make_compute(32'h7FFFFFFF, 32'h12345678, 32'h00020000));
      pending_reqs.push_back(make_compute(32'h80000000, 32'hEDCBA987, 32'h7FFFFFFF));
      pending_reqs.push_back(make_compute(32'h002D0000, 32'h00050000, 32'hFFFFFFFF));
      pending_reqs.push_back(make_load(4'd0, 32'h7FFFFFFF));
      pending_reqs.push_back(make_load(4'd15, 32'h80000000));
      pending_reqs.push_back(make_load(4'd5, 32'hFFFFFFFF));
      pending_reqs.push_back(make_load(4'd10, 32'h00008000));
      pending_reqs.push_back(make_compute(32'h001E0000, 32'h00010000, 32'h00010000));
      drain_all();

      for (int p = 0; p < 7; p++) begin
         write_reg(CSR_ROTATION_ORDER, orders[p]);
         write_reg(CSR_USE_BASE, bases[p]);
         send_idle_pct = idle_mode[p % 4][0];
         recv_stall_pct = idle_mode[p % 4][1];
         if (p == 2) begin
            pending_reqs.push_back(make_compute(32'h005A0000, 32'h7FFFFFFF, 32'h7FFFFFFF));
            pending_reqs.push_back(make_compute(32'h80000000, 32'h80000000, 32'h80000000));
         end
         for (int n = 0; n < 23; n++) pending_reqs.push_back(make_random());
         drain_all();
      end

      $display("covered all rotation orders including the spare code, base on and off,");
      $display("%0d columns checked under four sender and receiver idling patterns",
               columns_seen);
      if (mismatches == 0) begin
         $display("tb_euler_trs_matrix_builder: clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb_euler_trs_matrix_builder: errors");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/etmb_pkg.sv
hdl/etmb_ctrl.sv
hdl/etmb_datapath.sv
hdl/euler_trs_matrix_builder.sv
sim/tb_euler_trs_matrix_builder.sv
